// File: hw/rtl/sorted_record_table_assert.svh
// Assertion macros for the sorted record table RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef SORTED_RECORD_TABLE_ASSERT_SVH
`define SORTED_RECORD_TABLE_ASSERT_SVH
`ifndef SYNTH
`define SRT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SRT_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRT_ASSERT(label, clk, rst, prop, msg)
`define SRT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// File: hw/rtl/srt_pkg.sv
// Package for the sorted record table: sizes, opcodes, status codes and
// the command/status structs between controller and datapath. No dependencies.
package srt_pkg;
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int MAX_RESULTS = 32;
  localparam int ID_W = 31;
  localparam int GRADE_W = 16;
  localparam int MIDX_W = $clog2(2 * DEPTH);
  localparam int MCNT_W = $clog2(2 * DEPTH + 1);

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_SEARCH = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_DUMP   = 3'd3;
  localparam logic [2:0] OP_RDUMP  = 3'd4;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_NOTFOUND = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_REC      = 3'd4;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [GRADE_W-1:0] grade;
  } rec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;      // capture the input beat
    logic             scan_clr;  // reset scan index
    logic             scan_inc;  // advance scan index
    logic             ins_step;  // shift one entry toward the tail for insert
    logic             ins_write; // write the new record at the scan index
    logic             del_step;  // shift one entry toward the head for delete
    logic             del_done;  // decrement the class count
    logic             mrg_clr;   // reset merge pointers
    logic             mrg_step;  // take one entry into the merge order
    logic             emit_clr;  // reset emit pointer
    logic             emit_inc;  // advance emit pointer
  } srt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic       scan_end;  // scan index reached the class count
    logic       id_hit;    // entry at scan index has the key
    logic       grade_le;  // entry at scan index has grade <= new grade
    logic       full;
    logic       shift_end; // shift pointer reached the scan index
    logic       del_end;   // delete shift reached the tail
    logic       mrg_end;   // both classes consumed
    logic       mrg_empty;
    logic       emit_end;  // emit pointer at final record
  } srt_stat_t;
endpackage

// File: hw/rtl/srt_if.sv
// Valid/ready channel interfaces for the sorted record table.
// Depends on srt_pkg.
interface srt_in_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    opcode;
  logic                          class_sel;
  logic [srt_pkg::ID_W-1:0]      record_id;
  logic [srt_pkg::GRADE_W-1:0]   grade;
  modport source(output valid, opcode, class_sel, record_id, grade, input ready);
  modport sink(input valid, opcode, class_sel, record_id, grade, output ready);
endinterface

interface srt_out_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    status;
  logic                          rec_class;
  logic [srt_pkg::ID_W-1:0]      rec_id;
  logic [srt_pkg::GRADE_W-1:0]   rec_grade;
  logic                          last;
  modport source(output valid, status, rec_class, rec_id, rec_grade, last, input ready);
  modport sink(input valid, status, rec_class, rec_id, rec_grade, last, output ready);
endinterface

// File: hw/rtl/srt_datapath.sv
// Datapath of the sorted record table: record memories, class counts, scan,
// shift and merge pointers. Depends on srt_pkg.
module srt_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  srt_pkg::srt_cmd_t            cmd,
  output srt_pkg::srt_stat_t           stat,
  input  logic [2:0]                   in_op,
  input  logic                         in_cls,
  input  logic [srt_pkg::ID_W-1:0]     in_id,
  input  logic [srt_pkg::GRADE_W-1:0]  in_grade,
  output logic                         out_cls,
  output logic [srt_pkg::ID_W-1:0]     out_id,
  output logic [srt_pkg::GRADE_W-1:0]  out_grade,
  output logic                         hit_cls_rec,
  output logic                         ctr_clear
);
  import srt_pkg::*;

  // Both classes kept as register rows; every entry is read at a fixed place
  // for the shift, and the scan reads through a mux.
  rec_t store0 [DEPTH];
  rec_t store1 [DEPTH];
  logic [CNT_W-1:0] count [2];

  logic [2:0]         op;
  logic               cls;
  logic [ID_W-1:0]    key;
  logic [GRADE_W-1:0] grd;
  logic [CNT_W-1:0]   scan;
  logic [CNT_W-1:0]   shp;
  logic [CNT_W-1:0]   ma, mb;
  logic [MCNT_W-1:0]  mlen;
  logic [MIDX_W-1:0]  eptr;
  logic [2*DEPTH-1:0] mcls;
  logic [IDX_W-1:0]   midx [2*DEPTH];

  logic [CNT_W-1:0] cnt_sel;
  rec_t             scan_rec;
  rec_t             ra, rb;
  logic             take0;
  logic [MIDX_W-1:0] sel_pos;
  logic             sel_c;
  rec_t             sel_rec;

  assign cnt_sel  = count[cls];
  assign scan_rec = cls ? store1[scan[IDX_W-1:0]] : store0[scan[IDX_W-1:0]];
  assign ra = store0[ma[IDX_W-1:0]];
  assign rb = store1[mb[IDX_W-1:0]];

  always_comb begin
    if (ma < count[0] && mb < count[1]) begin
      take0 = ra.grade >= rb.grade;
    end else begin
      take0 = ma < count[0];
    end
  end

  always_comb begin
    if (op == OP_RDUMP) begin
      sel_pos = MIDX_W'(mlen - MCNT_W'(1) - MCNT_W'(eptr));
    end else begin
      sel_pos = eptr;
    end
    sel_c   = mcls[sel_pos];
    sel_rec = sel_c ? store1[midx[sel_pos]] : store0[midx[sel_pos]];
  end

  always_comb begin
    stat.op        = op;
    stat.scan_end  = scan >= cnt_sel;
    stat.id_hit    = scan_rec.id == key;
    stat.grade_le  = scan_rec.grade <= grd;
    stat.full      = cnt_sel >= CNT_W'(DEPTH);
    stat.shift_end = shp == scan;
    stat.del_end   = (scan + CNT_W'(1)) >= cnt_sel;
    stat.mrg_end   = (ma >= count[0]) && (mb >= count[1]);
    stat.mrg_empty = mlen == '0;
    stat.emit_end  = (MCNT_W'(eptr) + MCNT_W'(1) >= mlen) ||
                     (MCNT_W'(eptr) + MCNT_W'(1) >= MCNT_W'(MAX_RESULTS));
  end

  // Reported record: the scanned entry for search/delete, the new record for insert, else the merge pick.
  // A scan that ran off the end of the class reports the key itself.
  assign out_cls     = (op == OP_DUMP || op == OP_RDUMP) ? sel_c : cls;
  assign out_id      = (op == OP_DUMP || op == OP_RDUMP) ? sel_rec.id :
                       (op == OP_INSERT || stat.scan_end) ? key : scan_rec.id;
  assign out_grade   = (op == OP_DUMP || op == OP_RDUMP) ? sel_rec.grade :
                       (op == OP_INSERT) ? grd : scan_rec.grade;
  assign hit_cls_rec = cls;
  assign ctr_clear   = stat.mrg_empty;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= in_op;
      cls <= in_cls;
      key <= in_id;
      grd <= in_grade;
    end
    if (cmd.scan_clr) begin
      scan <= '0;
    end else if (cmd.scan_inc) begin
      scan <= scan + CNT_W'(1);
    end
    if (cmd.scan_clr) begin
      shp <= cnt_sel;
    end else if (cmd.ins_step) begin
      shp <= shp - CNT_W'(1);
    end
    if (cmd.ins_step) begin
      if (cls) begin
        store1[shp[IDX_W-1:0]] <= store1[shp[IDX_W-1:0] - IDX_W'(1)];
      end else begin
        store0[shp[IDX_W-1:0]] <= store0[shp[IDX_W-1:0] - IDX_W'(1)];
      end
    end
    if (cmd.ins_write) begin
      if (cls) begin
        store1[scan[IDX_W-1:0]] <= '{id: key, grade: grd};
      end else begin
        store0[scan[IDX_W-1:0]] <= '{id: key, grade: grd};
      end
    end
    if (cmd.del_step) begin
      if (cls) begin
        store1[scan[IDX_W-1:0]] <= store1[scan[IDX_W-1:0] + IDX_W'(1)];
      end else begin
        store0[scan[IDX_W-1:0]] <= store0[scan[IDX_W-1:0] + IDX_W'(1)];
      end
    end
    if (cmd.mrg_clr) begin
      ma   <= '0;
      mb   <= '0;
      mlen <= '0;
    end else if (cmd.mrg_step) begin
      mcls[mlen[MIDX_W-1:0]] <= ~take0;
      midx[mlen[MIDX_W-1:0]] <= take0 ? ma[IDX_W-1:0] : mb[IDX_W-1:0];
      if (take0) begin
        ma <= ma + CNT_W'(1);
      end else begin
        mb <= mb + CNT_W'(1);
      end
      mlen <= mlen + MCNT_W'(1);
    end
    if (cmd.emit_clr) begin
      eptr <= '0;
    end else if (cmd.emit_inc) begin
      eptr <= eptr + MIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count[0] <= '0;
      count[1] <= '0;
    end else if (cmd.ins_write) begin
      count[cls] <= count[cls] + CNT_W'(1);
    end else if (cmd.del_done) begin
      count[cls] <= count[cls] - CNT_W'(1);
    end
  end
endmodule

// File: hw/rtl/srt_ctrl.sv
// Controller state machine of the sorted record table: sequences scans,
// shifts, merges and result beats. Depends on srt_pkg and the assert header.
`include "sorted_record_table_assert.svh"
module srt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_status,
  output logic                out_last,
  output logic                out_zero,
  output srt_pkg::srt_cmd_t   cmd,
  input  srt_pkg::srt_stat_t  stat
);
  import srt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FIND  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DEL   = 3'd4;
  localparam logic [2:0] S_MERGE = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;
  localparam logic [2:0] S_RES   = 3'd7;

  logic [2:0] state, state_next;
  logic [2:0] res_status, res_status_next;
  logic       found, found_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd = '0;
    state_next = state;
    res_status_next = res_status;
    found_next = found;
    out_valid = 1'b0;
    out_status = res_status;
    out_last = 1'b1;
    out_zero = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        // Scan and merge pointers start from the captured beat.
        cmd.scan_clr = 1'b1;
        cmd.mrg_clr = 1'b1;
        cmd.emit_clr = 1'b1;
        found_next = 1'b0;
        if (stat.op == OP_DUMP || stat.op == OP_RDUMP) begin
          state_next = S_MERGE;
        end else if (stat.op == OP_INSERT || stat.op == OP_SEARCH ||
                     stat.op == OP_DELETE) begin
          state_next = S_FIND;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FIND: begin
        if (stat.scan_end) begin
          if (stat.op == OP_INSERT) begin
            if (stat.full) begin
              res_status_next = ST_FULL;
              state_next = S_RES;
            end else begin
              // Rescan for the insertion point.
              cmd.scan_clr = 1'b1;
              found_next = 1'b1;
              state_next = S_SHIFT;
            end
          end else begin
            res_status_next = ST_NOTFOUND;
            state_next = S_RES;
          end
        end else if (stat.id_hit) begin
          if (stat.op == OP_INSERT) begin
            res_status_next = ST_DUP;
            state_next = S_RES;
          end else if (stat.op == OP_SEARCH) begin
            res_status_next = ST_REC;
            state_next = S_RES;
          end else begin
            res_status_next = ST_DONE;
            state_next = S_RES;
          end
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        // found marks the position search; clear it once position is fixed.
        if (found) begin
          if (stat.scan_end || stat.grade_le) begin
            found_next = 1'b0;
          end else begin
            cmd.scan_inc = 1'b1;
          end
        end else if (!stat.shift_end) begin
          cmd.ins_step = 1'b1;
        end else begin
          cmd.ins_write = 1'b1;
          res_status_next = ST_DONE;
          state_next = S_RES;
        end
      end
      S_DEL: begin
        if (stat.del_end) begin
          cmd.del_done = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.del_step = 1'b1;
          cmd.scan_inc = 1'b1;
        end
      end
      S_MERGE: begin
        if (stat.mrg_end) begin
          state_next = S_EMIT;
        end else begin
          cmd.mrg_step = 1'b1;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (stat.mrg_empty) begin
          out_status = ST_DONE;
          out_zero = 1'b1;
          if (out_ready) begin
            state_next = S_IDLE;
          end
        end else begin
          out_status = ST_REC;
          out_last = stat.emit_end;
          if (out_ready) begin
            if (stat.emit_end) begin
              state_next = S_IDLE;
            end else begin
              cmd.emit_inc = 1'b1;
            end
          end
        end
      end
      S_RES: begin
        out_valid = 1'b1;
        out_zero = res_status == ST_NOTFOUND;
        if (out_ready) begin
          // A delete hit compacts the table after its beat is taken.
          if (stat.op == OP_DELETE && res_status == ST_DONE) begin
            state_next = S_DEL;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_status <= ST_DONE;
      found <= 1'b0;
    end else begin
      state <= state_next;
      res_status <= res_status_next;
      found <= found_next;
    end
  end

  `SRT_ASSERT(a_ready_idle, clk, rst, in_ready |-> !out_valid, "ready while a result is shown")
  `SRT_ASSERT(a_one_write, clk, rst, !(cmd.ins_write && cmd.del_done), "insert and delete together")
  `SRT_ASSERT(a_accept_moves, clk, rst, (in_valid && in_ready) |=> (state == S_SCAN), "accepted beat not started")
endmodule

// File: hw/rtl/sorted_record_table.sv
// Top level of the sorted record table: joins controller and datapath.
// Depends on srt_pkg, srt_if, srt_ctrl, srt_datapath and the assert header.
//
// The block keeps two classes of (id, grade) records, each sorted by
// descending grade, and takes one operation per input beat: insert, search,
// delete, merged dump or reversed merged dump. It handles one operation at a
// time; input ready is high only when the previous operation has delivered
// all its result beats and finished any table update. Timing is set by the
// controller's one-entry-a-cycle scans. A search scans its class until a hit
// or the class end; an insert scans the class for a duplicate, then rescans
// for the insertion point and shifts the entries behind it toward the tail; a
// delete scans for the key and, on a hit, compacts the class after its result
// beat is taken; a dump builds the merge order and then gives its result
// beats, each held until out_ready takes it. Unused opcodes produce no result
// beat. After reset both classes are empty; no clearing pass is needed.
`include "sorted_record_table_assert.svh"
module sorted_record_table (
  input logic      clk,
  input logic      rst,
  srt_in_if.sink   in_ch,
  srt_out_if.source out_ch
);
  import srt_pkg::*;

  srt_cmd_t  cmd;
  srt_stat_t stat;
  logic [2:0] status;
  logic       zero;
  logic       dp_cls;
  logic [ID_W-1:0] dp_id;
  logic [GRADE_W-1:0] dp_grade;
  logic       cls_reg;
  logic       empty;

  srt_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_status(status), .out_last(out_ch.last), .out_zero(zero),
    .cmd(cmd), .stat(stat)
  );

  srt_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_op(in_ch.opcode), .in_cls(in_ch.class_sel),
    .in_id(in_ch.record_id), .in_grade(in_ch.grade),
    .out_cls(dp_cls), .out_id(dp_id), .out_grade(dp_grade),
    .hit_cls_rec(cls_reg), .ctr_clear(empty)
  );

  // An empty dump reports all zeros; a miss reports the key with grade zero.
  always_comb begin
    out_ch.status = status;
    if (zero && status == ST_DONE) begin
      out_ch.rec_class = 1'b0;
      out_ch.rec_id    = '0;
      out_ch.rec_grade = '0;
    end else if (zero) begin
      out_ch.rec_class = cls_reg;
      out_ch.rec_id    = dp_id;
      out_ch.rec_grade = '0;
    end else begin
      out_ch.rec_class = dp_cls;
      out_ch.rec_id    = dp_id;
      out_ch.rec_grade = dp_grade;
    end
  end

  // An empty-dump beat must see an empty merge.
  `SRT_ASSERT(a_empty_dump, clk, rst,
    (out_ch.valid && zero && status == ST_DONE) |-> empty, "empty dump with records")
endmodule
